// ===== sv/sct_pkg.sv =====
// shared types, constants and coefficient conversion for the sine/cosine/tangent unit
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

    // latency of the Q60 multiplier in cycles
    localparam int MUL_LAT = 4;

    // pi/4 in Q62
    localparam logic [61:0] PI4_Q62 = 62'h3243F6A8885A308D;

    // one in Q60
    localparam logic signed [63:0] ONE_Q60 = 64'sh1000_0000_0000_0000;

    // request codes
    typedef enum logic [1:0] {
        REQ_SIN = 2'd0,
        REQ_COS = 2'd1,
        REQ_TAN = 2'd2
    } sct_req_t;

    // fields that travel beside the multiplier operands
    typedef struct packed {
        logic [2:0]         quo;
        logic [1:0]         req;
        logic signed [63:0] x;
        logic signed [63:0] z;
    } sct_side_t;

    // decimal kernel coefficient rounded half up to Q60: sine set 0..5, cosine set 6..11
    function automatic logic signed [63:0] coef_q60(input int unsigned idx);
        logic [127:0] w;
        logic [63:0]  dig;
        logic [63:0]  q;
        int unsigned  ex;
        logic         neg;
        dig = 64'd0;
        ex  = 0;
        neg = 1'b0;
        case (idx)
            0:  begin dig = 64'd158962301576546568; ex = 27; neg = 1'b0; end
            1:  begin dig = 64'd250507477628578073; ex = 25; neg = 1'b1; end
            2:  begin dig = 64'd275573136213857245; ex = 23; neg = 1'b0; end
            3:  begin dig = 64'd198412698295895386; ex = 21; neg = 1'b1; end
            4:  begin dig = 64'd833333333332211859; ex = 20; neg = 1'b0; end
            5:  begin dig = 64'd166666666666666307; ex = 18; neg = 1'b1; end
            6:  begin dig = 64'd113585365213876817; ex = 28; neg = 1'b1; end
            7:  begin dig = 64'd208757008419747317; ex = 26; neg = 1'b0; end
            8:  begin dig = 64'd275573141792967388; ex = 24; neg = 1'b1; end
            9:  begin dig = 64'd248015872888517045; ex = 22; neg = 1'b0; end
            10: begin dig = 64'd138888888888730564; ex = 20; neg = 1'b1; end
            11: begin dig = 64'd416666666666665929; ex = 19; neg = 1'b0; end
            default: begin dig = 64'd0; ex = 0; neg = 1'b0; end
        endcase
        w = {64'd0, dig} << 61;
        for (int i = 0; i < 30; i++) begin
            if (i < ex) begin
                w = w / 128'd10;
            end
        end
        q = (w[63:0] + 64'd1) >> 1;
        return neg ? $signed(64'd0 - q) : $signed(q);
    endfunction

endpackage

`default_nettype wire

// ===== sv/sct_if.sv =====
// valid/ready channel interfaces for angle requests and results
`timescale 1ns / 1ps
`default_nettype none

interface sct_in_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] angle;
    logic [1:0]        req_type;

    modport source (output valid, output angle, output req_type, input ready);
    modport sink   (input valid, input angle, input req_type, output ready);
endinterface

interface sct_out_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] value;
    logic              saturated;

    modport source (output valid, output value, output saturated, input ready);
    modport sink   (input valid, input value, input saturated, output ready);
endinterface

`default_nettype wire

// ===== sv/sct_mul.sv =====
// two-lane pipelined signed Q60 multiplier with sideband delay line
`timescale 1ns / 1ps
`default_nettype none

module sct_mul (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_vld,
    input  sct_pkg::sct_side_t     side_in,
    input  logic signed [63:0]     a0,
    input  logic signed [63:0]     b0,
    input  logic signed [63:0]     a1,
    input  logic signed [63:0]     b1,
    output logic                   out_vld,
    output sct_pkg::sct_side_t     side_out,
    output logic signed [63:0]     p0,
    output logic signed [63:0]     p1
);
    import sct_pkg::*;

    logic [MUL_LAT-1:0] vld_reg;
    sct_side_t          side_reg [MUL_LAT];

    logic signed [63:0] op_a [2];
    logic signed [63:0] op_b [2];
    logic [127:0]       sum  [2];

    logic [1:0]         neg1_reg;
    logic [1:0]         neg2_reg;
    logic [1:0]         neg3_reg;
    logic [63:0]        ua_reg   [2];
    logic [63:0]        ub_reg   [2];
    logic [63:0]        pp0_reg  [2];
    logic [63:0]        pp1_reg  [2];
    logic [63:0]        pp2_reg  [2];
    logic [63:0]        pp3_reg  [2];
    logic [63:0]        mag_reg  [2];
    logic signed [63:0] prod_reg [2];

    assign op_a[0] = a0;
    assign op_b[0] = b0;
    assign op_a[1] = a1;
    assign op_b[1] = b1;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[MUL_LAT-2:0], in_vld};
        end
    end

    // sideband delay line
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < MUL_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // full 128-bit magnitude product, Q60 window is bits 123:60
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            sum[l] = {pp3_reg[l], 64'd0}
                   + {32'd0, pp1_reg[l], 32'd0}
                   + {32'd0, pp2_reg[l], 32'd0}
                   + {64'd0, pp0_reg[l]};
        end
    end

    // magnitude, partial products, sum, sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 2; l++)
            begin
                neg1_reg[l] <= op_a[l][63] ^ op_b[l][63];
                ua_reg[l]   <= op_a[l][63] ? (64'd0 - $unsigned(op_a[l])) : $unsigned(op_a[l]);
                ub_reg[l]   <= op_b[l][63] ? (64'd0 - $unsigned(op_b[l])) : $unsigned(op_b[l]);

                neg2_reg[l] <= neg1_reg[l];
                pp0_reg[l]  <= 64'(ua_reg[l][31:0])  * 64'(ub_reg[l][31:0]);
                pp1_reg[l]  <= 64'(ua_reg[l][31:0])  * 64'(ub_reg[l][63:32]);
                pp2_reg[l]  <= 64'(ua_reg[l][63:32]) * 64'(ub_reg[l][31:0]);
                pp3_reg[l]  <= 64'(ua_reg[l][63:32]) * 64'(ub_reg[l][63:32]);

                neg3_reg[l] <= neg2_reg[l];
                mag_reg[l]  <= sum[l][123:60];

                prod_reg[l] <= neg3_reg[l] ? $signed(64'd0 - mag_reg[l]) : $signed(mag_reg[l]);
            end
        end
    end

    assign out_vld  = vld_reg[MUL_LAT-1];
    assign side_out = side_reg[MUL_LAT-1];
    assign p0       = prod_reg[0];
    assign p1       = prod_reg[1];

endmodule

`default_nettype wire

// ===== sv/sine_cosine_tangent_unit.sv =====
// Sine, cosine or tangent of a signed fixed-point angle in radians. The angle
// (Q(32-FRAC_BITS).FRAC_BITS) is reduced modulo pi/4 one quotient bit per
// stage, both polynomial kernels of degree POLY_DEGREE run side by side on a
// shared pipelined Q60 multiplier per Horner step, and tangent goes through a
// 32-stage restoring divider, saturating with a flag when the quotient leaves
// the output range. One beat is accepted every cycle unless the pipe stalls.
// A beat passes in order through the reduction stages, the Horner steps,
// each a multiplier plus one add, and the select, magnitude, divider,
// rounding and output buffer stages. A two-entry output buffer lets input keep
// flowing while a result waits; the whole pipe stalls only when that buffer is
// full and a finished beat is waiting for it. Request code 3 returns zero.
`timescale 1ns / 1ps
`default_nettype none

module sine_cosine_tangent_unit #(
    parameter int FRAC_BITS   = 24,
    parameter int POLY_DEGREE = 5
) (
    input  logic       clk,
    input  logic       rst_n,
    sct_in_if.sink     in_ch,
    sct_out_if.source  out_ch
);
    import sct_pkg::*;

    localparam int QW    = 32 - FRAC_BITS;
    localparam int QWX   = (QW < 3) ? 3 : QW;
    localparam int START = 5 - POLY_DEGREE;
    localparam int NSTEP = POLY_DEGREE + 3;
    localparam int NDIV  = 32;
    localparam logic [62:0] PQ  = 63'(PI4_Q62 >> (32 - FRAC_BITS));
    localparam logic [63:0] RND = 64'd1 << (59 - FRAC_BITS);

    localparam logic signed [63:0] CS [6] = '{coef_q60(0), coef_q60(1), coef_q60(2),
                                              coef_q60(3), coef_q60(4), coef_q60(5)};
    localparam logic signed [63:0] CC [6] = '{coef_q60(6), coef_q60(7), coef_q60(8),
                                              coef_q60(9), coef_q60(10), coef_q60(11)};

    typedef struct packed {
        logic             neg;
        logic [1:0]       req;
        logic [62:0]      rem;
        logic [QWX-1:0]   q;
    } red_t;

    typedef struct packed {
        sct_side_t          side;
        logic signed [63:0] acc_s;
        logic signed [63:0] acc_c;
    } kst_t;

    typedef struct packed {
        logic [1:0]  req;
        logic        tneg;
        logic        vneg;
        logic [63:0] uv;
        logic [63:0] us;
        logic [63:0] uc;
    } abs_t;

    typedef struct packed {
        logic [1:0]  req;
        logic        tneg;
        logic        vneg;
        logic [31:0] u;
        logic        ovf;
        logic [63:0] uc;
        logic [63:0] rem;
        logic [31:0] nlow;
        logic [31:0] qt;
    } div_t;

    logic en;

    red_t               red_reg  [QW+1];
    red_t               red_next [QW+1];
    logic [QW:0]        red_vld_reg;

    kst_t               kst_reg  [NSTEP+1];
    kst_t               kst_next [NSTEP+1];
    logic [NSTEP:0]     kst_vld_reg;

    sct_side_t          mside [NSTEP];
    logic signed [63:0] mp0   [NSTEP];
    logic signed [63:0] mp1   [NSTEP];
    logic [NSTEP-1:0]   mvld;

    logic signed [63:0] sel_s_next;
    logic signed [63:0] sel_c_next;
    logic signed [63:0] sel_s_reg;
    logic signed [63:0] sel_c_reg;
    logic [1:0]         sel_req_reg;
    logic               sel_vld_reg;

    abs_t               abs_next;
    abs_t               abs_reg;
    logic               abs_vld_reg;

    div_t               dv_reg  [NDIV+1];
    div_t               dv_next [NDIV+1];
    logic [NDIV:0]      dv_vld_reg;

    logic [31:0]        fin_value_next;
    logic               fin_sat_next;
    logic [31:0]        fin_value_reg;
    logic               fin_sat_reg;
    logic               fin_vld_reg;

    logic [31:0]        fifo_value_reg [2];
    logic               fifo_sat_reg   [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         cnt_reg;
    logic               push;
    logic               pop;
    logic               full;

    // pipe advances unless the final stage is blocked by a full buffer
    assign full        = (cnt_reg == 2'd2);
    assign en          = !(fin_vld_reg && full);
    assign in_ch.ready = en;

    // input stage: magnitude placed in Q(FRAC_BITS+30)
    always_comb
    begin
        logic [31:0] mag;
        mag = in_ch.angle[31] ? (32'd0 - $unsigned(in_ch.angle)) : $unsigned(in_ch.angle);
        red_next[0].neg = in_ch.angle[31];
        red_next[0].req = in_ch.req_type;
        red_next[0].rem = {1'b0, mag, 30'd0};
        red_next[0].q   = '0;
    end

    // reduction by pi/4, one quotient bit per stage
    for (genvar j = 1; j <= QW; j++)
    begin : g_red
        localparam logic [62:0] DK = 63'(PQ << (QW - j));
        always_comb
        begin
            red_next[j] = red_reg[j-1];
            if (red_reg[j-1].rem >= DK)
            begin
                red_next[j].rem      = red_reg[j-1].rem - DK;
                red_next[j].q[QW-j]  = 1'b1;
            end
        end
    end

    // octant fold: mirror the remainder and form the kernel argument
    always_comb
    begin
        logic [62:0] r;
        logic [62:0] rr;
        logic [2:0]  quo;
        logic        flip1;
        r     = red_reg[QW].rem;
        flip1 = red_reg[QW].neg && (r != '0);
        quo   = flip1 ? ~red_reg[QW].q[2:0] : red_reg[QW].q[2:0];
        rr    = (flip1 ^ quo[0]) ? (PQ - r) : r;
        kst_next[0].side.quo = quo;
        kst_next[0].side.req = red_reg[QW].req;
        kst_next[0].side.x   = $signed(64'(rr) << (30 - FRAC_BITS));
        kst_next[0].side.z   = '0;
        kst_next[0].acc_s    = '0;
        kst_next[0].acc_c    = '0;
    end

    // Horner steps: square, polynomial terms, then the kernel finish
    for (genvar g = 0; g < NSTEP; g++)
    begin : g_step
        localparam int CI = (START + g > 5) ? 5 : START + g;
        logic signed [63:0] op_a0;
        logic signed [63:0] op_b0;
        logic signed [63:0] op_a1;
        logic signed [63:0] op_b1;

        always_comb
        begin
            if (g == 0)
            begin
                op_a0 = kst_reg[g].side.x;
                op_b0 = kst_reg[g].side.x;
                op_a1 = kst_reg[g].side.x;
                op_b1 = kst_reg[g].side.x;
            end
            else if (g <= POLY_DEGREE + 1)
            begin
                op_a0 = kst_reg[g].acc_s;
                op_b0 = kst_reg[g].side.z;
                op_a1 = kst_reg[g].acc_c;
                op_b1 = kst_reg[g].side.z;
            end
            else
            begin
                op_a0 = kst_reg[g].acc_s;
                op_b0 = kst_reg[g].side.x;
                op_a1 = kst_reg[g].acc_c;
                op_b1 = kst_reg[g].side.z;
            end
        end

        sct_mul u_mul (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (kst_vld_reg[g]),
            .side_in  (kst_reg[g].side),
            .a0       (op_a0),
            .b0       (op_b0),
            .a1       (op_a1),
            .b1       (op_b1),
            .out_vld  (mvld[g]),
            .side_out (mside[g]),
            .p0       (mp0[g]),
            .p1       (mp1[g])
        );

        always_comb
        begin
            kst_next[g+1].side = mside[g];
            if (g == 0)
            begin
                kst_next[g+1].side.z = mp0[g];
                kst_next[g+1].acc_s  = CS[START];
                kst_next[g+1].acc_c  = CC[START];
            end
            else if (g <= POLY_DEGREE)
            begin
                kst_next[g+1].acc_s = mp0[g] + CS[CI];
                kst_next[g+1].acc_c = mp1[g] + CC[CI];
            end
            else if (g == POLY_DEGREE + 1)
            begin
                kst_next[g+1].acc_s = ONE_Q60 + mp0[g];
                kst_next[g+1].acc_c = mp1[g];
            end
            else
            begin
                kst_next[g+1].acc_s = mp0[g];
                kst_next[g+1].acc_c = ONE_Q60 - (mside[g].z >>> 1) + mp1[g];
            end
        end
    end

    // octant selects kernel and sign for sine and cosine
    always_comb
    begin
        logic [2:0]         quo;
        logic [2:0]         qs1;
        logic [2:0]         qc;
        logic [2:0]         qc1;
        logic signed [63:0] ks;
        logic signed [63:0] kc;
        quo = kst_reg[NSTEP].side.quo;
        ks  = kst_reg[NSTEP].acc_s;
        kc  = kst_reg[NSTEP].acc_c;
        qs1 = quo + 3'd1;
        qc  = quo + 3'd2;
        qc1 = quo + 3'd3;
        sel_s_next = qs1[1] ? kc : ks;
        if (quo[2])
        begin
            sel_s_next = -sel_s_next;
        end
        sel_c_next = qc1[1] ? kc : ks;
        if (qc[2])
        begin
            sel_c_next = -sel_c_next;
        end
    end

    // magnitudes and signs
    always_comb
    begin
        logic signed [63:0] v;
        v = (sel_req_reg == REQ_COS) ? sel_c_reg : sel_s_reg;
        abs_next.req  = sel_req_reg;
        abs_next.tneg = sel_s_reg[63] ^ sel_c_reg[63];
        abs_next.vneg = v[63];
        abs_next.uv   = v[63] ? (64'd0 - $unsigned(v)) : $unsigned(v);
        abs_next.us   = sel_s_reg[63] ? (64'd0 - $unsigned(sel_s_reg)) : $unsigned(sel_s_reg);
        abs_next.uc   = sel_c_reg[63] ? (64'd0 - $unsigned(sel_c_reg)) : $unsigned(sel_c_reg);
    end

    // output rounding and divider setup
    always_comb
    begin
        logic [63:0] rsum;
        logic [63:0] r0;
        rsum = abs_reg.uv + RND;
        r0   = abs_reg.us >> (31 - FRAC_BITS);
        dv_next[0].req  = abs_reg.req;
        dv_next[0].tneg = abs_reg.tneg;
        dv_next[0].vneg = abs_reg.vneg;
        dv_next[0].u    = 32'(rsum >> (60 - FRAC_BITS));
        dv_next[0].ovf  = (r0 >= abs_reg.uc);
        dv_next[0].uc   = abs_reg.uc;
        dv_next[0].rem  = r0;
        dv_next[0].nlow = 32'(abs_reg.us << (FRAC_BITS + 1));
        dv_next[0].qt   = '0;
    end

    // restoring divider, one quotient bit per stage
    for (genvar d = 1; d <= NDIV; d++)
    begin : g_div
        logic [64:0] t;
        logic [64:0] dvs;
        assign t   = {dv_reg[d-1].rem, dv_reg[d-1].nlow[NDIV-d]};
        assign dvs = {1'b0, dv_reg[d-1].uc};
        always_comb
        begin
            dv_next[d] = dv_reg[d-1];
            if (t >= dvs)
            begin
                dv_next[d].rem        = 64'(t - dvs);
                dv_next[d].qt[NDIV-d] = 1'b1;
            end
            else
            begin
                dv_next[d].rem = t[63:0];
            end
        end
    end

    // final rounding, saturation and sign
    always_comb
    begin
        logic [32:0] q33;
        logic [31:0] qv;
        logic [31:0] lim;
        logic [31:0] qsel;
        logic        sat;
        q33  = {1'b0, dv_reg[NDIV].qt} + 33'd1;
        qv   = q33[32:1];
        lim  = dv_reg[NDIV].tneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        sat  = dv_reg[NDIV].ovf || (qv > lim);
        qsel = sat ? lim : qv;
        case (dv_reg[NDIV].req) inside
            REQ_SIN, REQ_COS:
            begin
                fin_value_next = dv_reg[NDIV].vneg ? (32'd0 - dv_reg[NDIV].u) : dv_reg[NDIV].u;
                fin_sat_next   = 1'b0;
            end
            REQ_TAN:
            begin
                fin_value_next = dv_reg[NDIV].tneg ? (32'd0 - qsel) : qsel;
                fin_sat_next   = sat;
            end
            default:
            begin
                fin_value_next = '0;
                fin_sat_next   = 1'b0;
            end
        endcase
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_vld_reg <= '0;
            kst_vld_reg <= '0;
            sel_vld_reg <= 1'b0;
            abs_vld_reg <= 1'b0;
            dv_vld_reg  <= '0;
            fin_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            red_vld_reg <= {red_vld_reg[QW-1:0], in_ch.valid};
            kst_vld_reg <= {mvld, red_vld_reg[QW]};
            sel_vld_reg <= kst_vld_reg[NSTEP];
            abs_vld_reg <= sel_vld_reg;
            dv_vld_reg  <= {dv_vld_reg[NDIV-1:0], abs_vld_reg};
            fin_vld_reg <= dv_vld_reg[NDIV];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= QW; i++)
            begin
                red_reg[i] <= red_next[i];
            end
            for (int i = 0; i <= NSTEP; i++)
            begin
                kst_reg[i] <= kst_next[i];
            end
            sel_s_reg   <= sel_s_next;
            sel_c_reg   <= sel_c_next;
            sel_req_reg <= kst_reg[NSTEP].side.req;
            abs_reg     <= abs_next;
            for (int i = 0; i <= NDIV; i++)
            begin
                dv_reg[i] <= dv_next[i];
            end
            fin_value_reg <= fin_value_next;
            fin_sat_reg   <= fin_sat_next;
        end
    end

    // two-entry output buffer
    assign push = fin_vld_reg && !full;
    assign pop  = out_ch.valid && out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_value_reg[wr_ptr_reg] <= fin_value_reg;
            fifo_sat_reg[wr_ptr_reg]   <= fin_sat_reg;
        end
    end

    assign out_ch.valid     = (cnt_reg != 2'd0);
    assign out_ch.value     = $signed(fifo_value_reg[rd_ptr_reg]);
    assign out_ch.saturated = fifo_sat_reg[rd_ptr_reg];

`ifndef ASSERT_OFF
    // a blocked final beat holds until the buffer drains
    assert property (@(posedge clk) disable iff (!rst_n)
        (fin_vld_reg && !en) |=> (fin_vld_reg && $stable(fin_value_reg)))
        else $error("final stage lost or changed a stalled beat");

    // a clipped result is always one of the two limits
    assert property (@(posedge clk) disable iff (!rst_n)
        (fin_vld_reg && fin_sat_reg) |->
            (fin_value_reg == 32'h7FFF_FFFF || fin_value_reg == 32'h8000_0000))
        else $error("saturated result is not a range limit");

    // buffer occupancy stays within its two entries
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |=> !(cnt_reg == 2'd3) && !($past(push) && !$past(pop)))
        else $error("output buffer overflow");
`endif

endmodule

`default_nettype wire
